FILE: design/cpfm_pkg.sv
// Shared types and constants of the capture-pair frequency meter.
`timescale 1ns / 1ps
`default_nettype none

package cpfm_pkg;

  localparam int unsigned STAMP_W  = 16;
  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned RATE_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_CNT_W = $clog2(RATE_W);

  localparam logic [STAMP_W-1:0] TOP_RESET  = 16'd1388;
  localparam logic [RATE_W-1:0]  RATE_RESET = 24'(16000000 / 256);

  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE_HZ = 2'd1;

  localparam logic KIND_CAPTURE = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [STAMP_W-1:0] capture_value;
  } in_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_ticks;
    logic [RATE_W-1:0]   frequency_hz;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: design/cpfm_divider.sv
// Bit-serial restoring divider: one quotient bit per clock cycle.
`timescale 1ns / 1ps
`default_nettype none

module cpfm_divider (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire  [cpfm_pkg::RATE_W-1:0]       dividend,
  input  wire  [cpfm_pkg::PERIOD_W-1:0]     divisor,
  output cpfm_pkg::div_stat_t               stat,
  output logic [cpfm_pkg::RATE_W-1:0]       quotient
);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dstate_t;

  localparam logic [cpfm_pkg::DIV_CNT_W-1:0] LAST_STEP =
    cpfm_pkg::DIV_CNT_W'(cpfm_pkg::RATE_W - 1);

  dstate_t                            state_r, state_nxt;
  logic [cpfm_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [cpfm_pkg::PERIOD_W-1:0]      rem_r, rem_nxt;
  logic [cpfm_pkg::PERIOD_W-1:0]      dvs_r, dvs_nxt;
  logic [cpfm_pkg::RATE_W-1:0]        quo_r, quo_nxt;
  logic                               done_r, done_nxt;

  logic [cpfm_pkg::PERIOD_W:0]        trial;
  logic [cpfm_pkg::PERIOD_W:0]        diff;
  logic                               fits;

  // The partial remainder stays below the divisor, so the shifted trial value
  // needs one extra bit only.
  assign trial = {rem_r, quo_r[cpfm_pkg::RATE_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          state_nxt = D_RUN;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          dvs_nxt   = divisor;
          quo_nxt   = dividend;
        end
      end
      D_RUN: begin
        rem_nxt = fits ? diff[cpfm_pkg::PERIOD_W-1:0] : trial[cpfm_pkg::PERIOD_W-1:0];
        quo_nxt = {quo_r[cpfm_pkg::RATE_W-2:0], fits};
        cnt_nxt = cnt_r + cpfm_pkg::DIV_CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = D_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = (state_r == D_RUN);
  assign stat.done = done_r;
  assign quotient  = quo_r;

`ifndef NO_ASSERTIONS
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r == D_RUN))
    else $error("divider finished without running");
`endif

endmodule

`default_nettype wire

FILE: design/capture_pair_frequency_meter_core.sv
// Top level of the capture-pair period and frequency meter.
`timescale 1ns / 1ps
`default_nettype none

// The block takes timer values captured on rising edges of a counter that
// runs from zero to counter_top and wraps. Captures are paired: the first of
// a pair is stored and the second yields the elapsed ticks, with one wrap
// counted as counter_top+1 ticks when the second capture is not above the
// first. A restart transaction drops a half-finished pair. Each completed
// pair gives one result transaction carrying the period in ticks and the
// integer quotient tick_rate_hz / period_ticks; a zero period, which only
// out-of-range captures can produce, reports a frequency of zero. Restart
// and first-capture transactions leave the block idle. A second capture
// launches the bit-serial divider, which produces one of the 24 quotient
// bits per cycle; the quotient then moves into the output register, and
// in_stall stays high from the launch until the quotient has moved, also
// while it waits. The output register lets a division run while an earlier
// result still waits to be taken; a finished quotient is held until that
// register is free. The configuration registers are written through
// cfg_we, cfg_index and cfg_wdata; indexes beyond the two registers are
// ignored, and writes are expected only while the block is idle.

module capture_pair_frequency_meter_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  cpfm_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output cpfm_pkg::out_t                     out_data,
  input  wire                                cfg_we,
  input  wire  [cpfm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [cpfm_pkg::RATE_W-1:0]        cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            phase_r, phase_nxt;
  logic [cpfm_pkg::STAMP_W-1:0]    first_r, first_nxt;
  logic [cpfm_pkg::PERIOD_W-1:0]   period_r, period_nxt;
  logic                            out_valid_r, out_valid_nxt;
  cpfm_pkg::out_t                  out_r, out_nxt;
  logic                            start_r, start_nxt;

  logic [cpfm_pkg::STAMP_W-1:0]    top_r;
  logic [cpfm_pkg::RATE_W-1:0]     rate_r;

  cpfm_pkg::div_stat_t             div_stat;
  logic [cpfm_pkg::RATE_W-1:0]     div_quo;

  logic                            in_acc;
  logic                            out_free;
  logic                            load_out;
  logic [cpfm_pkg::PERIOD_W-1:0]   pair_period;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= cpfm_pkg::TOP_RESET;
      rate_r <= cpfm_pkg::RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpfm_pkg::REG_COUNTER_TOP:  top_r  <= cfg_wdata[cpfm_pkg::STAMP_W-1:0];
        cpfm_pkg::REG_TICK_RATE_HZ: rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Elapsed ticks between the stored and the new capture. When the new
  // capture is not above the stored one, a full wrap of counter_top+1 ticks
  // is added; the sum is taken modulo 2^17.
  always_comb begin
    if (first_r < in_data.capture_value) begin
      pair_period = {1'b0, in_data.capture_value} - {1'b0, first_r};
    end else begin
      pair_period = {1'b0, top_r} + {{(cpfm_pkg::PERIOD_W-1){1'b0}}, 1'b1}
                    + {1'b0, in_data.capture_value} - {1'b0, first_r};
    end
  end

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // The quotient moves to the output once the division is over and the
  // output register is empty or being emptied in this cycle.
  assign load_out = ((state_r == S_DIV && div_stat.done) || state_r == S_HOLD) && out_free;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    first_nxt     = first_r;
    period_nxt    = period_r;
    start_nxt     = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == cpfm_pkg::KIND_RESTART) begin
            phase_nxt = 1'b0;
          end else if (!phase_r) begin
            first_nxt = in_data.capture_value;
            phase_nxt = 1'b1;
          end else begin
            phase_nxt  = 1'b0;
            period_nxt = pair_period;
            start_nxt  = 1'b1;
            state_nxt  = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (load_out) begin
      out_valid_nxt        = 1'b1;
      out_nxt.period_ticks = period_r;
      out_nxt.frequency_hz = (period_r == '0) ? '0 : div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    first_r  <= first_nxt;
    period_r <= period_nxt;
    out_r    <= out_nxt;
  end

  cpfm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (rate_r),
    .divisor  (period_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider result arrived outside a division");

  a_pair_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.kind == cpfm_pkg::KIND_CAPTURE && phase_r) |=>
      (state_r == S_DIV && start_r))
    else $error("completed pair did not launch a division");

  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.period_ticks == '0) |-> (out_r.frequency_hz == '0))
    else $error("zero period reported a nonzero frequency");

  a_div_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_stat.busy)
    else $error("divider running while the block accepts input");
`endif

endmodule

`default_nettype wire
